// ----- design/cwap_pkg.sv -----
// ----------------------------------------------------------------------------
// cwap_pkg
// Shared types and field widths for the channel window average and peak
// cost core.
// ----------------------------------------------------------------------------
package cwap_pkg;

    localparam int CH_W     = 6;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;
    localparam int PEAK_W   = 16;
    localparam int COST_W   = 22;
    localparam int MODE_W   = 2;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 64;
    localparam int CFG_AW   = 3;

    // configuration register byte addresses
    localparam logic [CFG_AW-1:0] ADDR_RUN_MODE       = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_ACTIVE_CHANNEL = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        RUN_STOP  = 2'd0,
        RUN_AVG   = 2'd1,
        RUN_PEAK  = 2'd2,
        RUN_SPARE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_PORT,
        SEL_HOLD,
        SEL_SCAN
    } t_addr_sel;

    // controller to datapath
    typedef struct packed {
        logic      take;
        t_addr_sel addr_sel;
        logic      clr_step;
        logic      commit;
        logic      load_step;
        logic      scan_step;
        logic      load_cost;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic enter_avg;
        logic clr_last;
        logic cost_due;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// ----- design/channel_window_average_peak_cost_core.sv -----
// ----------------------------------------------------------------------------
// channel_window_average_peak_cost_core
// Per-channel moving-window sum and peak detector with record-end cost.
// ----------------------------------------------------------------------------
// One result per input transaction. A sample in stop or average mode, or a
// non-final sample in analyse mode, is accepted with a memory read, then
// written back. A record end in analyse mode adds the cost scan, which
// reads the sum and peak memories one channel per cycle. The first sample
// after entering average mode adds a clear pass that zeroes the sample ring
// one entry per cycle; configuration writes are taken throughout.
module channel_window_average_peak_cost_core #(
    parameter int CHANNELS = 64,
    parameter int WINDOW   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // stream in
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cwap_pkg::IN_W-1:0]   s_axis_tdata,  // channel[5:0], sample[21:6]
    input  logic                        s_axis_tlast,  // record_end
    // stream out
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cwap_pkg::OUT_W-1:0]  m_axis_tdata,  // out_channel[5:0],
                                                       // window_sum[25:6],
                                                       // peak[41:26], cost[63:42]
    output logic                        m_axis_tuser,  // cost_valid
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cwap_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cwap_pkg::*;

    logic [MODE_W-1:0] r_run_mode;
    logic [CH_W-1:0]   r_active_channel;
    logic              cfg_wr;
    t_cmd              cmd;
    t_stat             stat;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_mode       <= RUN_STOP;
            r_active_channel <= '0;
        end else if (cfg_wr) begin
            if (paddr == ADDR_RUN_MODE) begin
                r_run_mode <= pwdata[MODE_W-1:0];
            end else if (paddr == ADDR_ACTIVE_CHANNEL) begin
                r_active_channel <= pwdata[CH_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_RUN_MODE) begin
            prdata = 32'(r_run_mode);
        end else if (paddr == ADDR_ACTIVE_CHANNEL) begin
            prdata = 32'(r_active_channel);
        end
    end

    cwap_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    cwap_dp #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_run_mode       (r_run_mode),
        .i_active_channel (r_active_channel),
        .i_channel        (s_axis_tdata[CH_W-1:0]),
        .i_sample         (s_axis_tdata[CH_W+SAMPLE_W-1:CH_W]),
        .i_record_end     (s_axis_tlast),
        .i_m_ready        (m_axis_tready),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_m_valid        (m_axis_tvalid),
        .o_m_data         (m_axis_tdata),
        .o_m_user         (m_axis_tuser)
    );

endmodule

// ----- design/cwap_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwap_ctrl
// Sequencer: accepts a transaction, runs the ring clear pass, the
// read-modify-write and the record-end cost scan.
// ----------------------------------------------------------------------------
module cwap_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  cwap_pkg::t_stat i_stat,
    output cwap_pkg::t_cmd  o_cmd
);
    import cwap_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.addr_sel = SEL_HOLD;
        o_s_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready      = 1'b1;
                o_cmd.addr_sel = SEL_PORT;
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_stat.enter_avg ? ST_CLEAR : ST_UPDATE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    if (i_stat.cost_due) begin
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.load_step = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.addr_sel  = SEL_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_cost = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a taken transaction always blocks the input in the next cycle
    a_take_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> !o_s_ready)
        else $error("input ready right after a take");

    // clear pass and write back never overlap
    a_clr_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.clr_step && o_cmd.commit))
        else $error("clear step and commit together");

    // the cost scan is only entered from a commit
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SCAN) |-> $past(o_cmd.commit))
        else $error("scan entered without commit");

endmodule

// ----- design/cwap_dp.sv -----
// ----------------------------------------------------------------------------
// cwap_dp
// Datapath: sample ring, per-channel sum and peak memories, cost scan
// accumulator and output register.
// ----------------------------------------------------------------------------
module cwap_dp #(
    parameter int CHANNELS = 64,
    parameter int WINDOW   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cwap_pkg::MODE_W-1:0]   i_run_mode,
    input  logic [cwap_pkg::CH_W-1:0]     i_active_channel,
    input  logic [cwap_pkg::CH_W-1:0]     i_channel,
    input  logic [cwap_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_record_end,
    input  logic                          i_m_ready,
    input  cwap_pkg::t_cmd                i_cmd,
    output cwap_pkg::t_stat               o_stat,
    output logic                          o_m_valid,
    output logic [cwap_pkg::OUT_W-1:0]    o_m_data,
    output logic                          o_m_user
);
    import cwap_pkg::*;

    localparam int CHB   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW    = $clog2(WINDOW);
    localparam int RD    = CHANNELS * WINDOW;
    localparam int RAW   = $clog2(RD);
    localparam int SCW   = 18 + $clog2(WINDOW + 1);
    localparam int DW    = SCW + 1;

    // memories
    logic [SAMPLE_W-1:0] ring_mem [RD];
    logic [SUM_W-1:0]    sum_mem  [CHANNELS];
    logic [PEAK_W-1:0]   peak_mem [CHANNELS];
    logic [CHANNELS-1:0] r_sum_vld;
    logic [CHANNELS-1:0] r_peak_vld;

    // held step
    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_last;
    t_mode               r_mode;
    logic [MODE_W-1:0]   r_prev_mode;
    logic [PW-1:0]       r_ring_pos;
    logic [RAW-1:0]      r_clr_addr;

    // read data
    logic [SAMPLE_W-1:0] r_ring_rd;
    logic [SUM_W-1:0]    r_sum_rd;
    logic [PEAK_W-1:0]   r_peak_rd;

    // scan
    logic [CHB-1:0]         r_scan_cnt;
    logic [CHB-1:0]         r_scan_idx;
    logic                   r_scan_v;
    logic signed [SCW-1:0]  r_best;
    logic signed [SCW-1:0]  r_own;

    // output register
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_user;
    logic [SUM_W-1:0]   r_step_sum;
    logic [PEAK_W-1:0]  r_step_peak;

    logic [CHB-1:0]  port_idx;
    logic [CHB-1:0]  hold_idx;
    logic            hold_in_range;
    logic [CHB-1:0]  mem_addr;
    logic [RAW-1:0]  ring_raddr;
    logic [RAW-1:0]  hold_ring_addr;
    logic [RAW-1:0]  port_ring_addr;
    logic [SUM_W-1:0]  sum_old;
    logic [PEAK_W-1:0] peak_old;
    logic [SUM_W-1:0]  new_sum;
    logic [PEAK_W-1:0] abs_s;
    logic [PEAK_W-1:0] new_peak;
    logic [SUM_W-1:0]  step_sum;
    logic [PEAK_W-1:0] step_peak;
    logic [SUM_W-1:0]  scan_sum;
    logic [PEAK_W-1:0] scan_peak;
    logic [SCW-1:0]    scan_prod;
    logic signed [SCW-1:0] score;
    logic signed [DW-1:0]  cost_full;
    logic              scan_is_own;
    logic              do_avg;
    logic              do_ana;

    // channel indexes and addresses
    assign port_idx       = CHB'({2'b00, i_channel});
    assign hold_idx       = CHB'({2'b00, r_ch});
    assign hold_in_range  = ({3'b000, r_ch} < 9'(CHANNELS));
    assign port_ring_addr = RAW'(port_idx) * RAW'(WINDOW) + RAW'(r_ring_pos);
    assign hold_ring_addr = RAW'(hold_idx) * RAW'(WINDOW) + RAW'(r_ring_pos);

    always_comb begin
        unique case (i_cmd.addr_sel)
            SEL_PORT: begin
                mem_addr   = port_idx;
                ring_raddr = port_ring_addr;
            end
            SEL_SCAN: begin
                mem_addr   = r_scan_cnt;
                ring_raddr = hold_ring_addr;
            end
            default: begin
                mem_addr   = hold_idx;
                ring_raddr = hold_ring_addr;
            end
        endcase
    end

    assign do_avg = (r_mode == RUN_AVG) && hold_in_range;
    assign do_ana = (r_mode == RUN_PEAK) && hold_in_range;

    // step arithmetic
    assign sum_old  = (hold_in_range && r_sum_vld[hold_idx]) ? r_sum_rd : '0;
    assign peak_old = (hold_in_range && r_peak_vld[hold_idx]) ? r_peak_rd : '0;
    assign new_sum  = sum_old + SUM_W'($signed(r_sample)) - SUM_W'($signed(r_ring_rd));
    assign abs_s    = r_sample[SAMPLE_W-1] ? (PEAK_W'(0) - r_sample) : r_sample;
    assign new_peak = (abs_s > peak_old) ? abs_s : peak_old;
    assign step_sum  = do_avg ? new_sum : sum_old;
    assign step_peak = do_ana ? new_peak : peak_old;

    // scan arithmetic
    assign scan_sum    = r_sum_vld[r_scan_idx] ? r_sum_rd : '0;
    assign scan_peak   = r_peak_vld[r_scan_idx] ? r_peak_rd : '0;
    assign scan_prod   = SCW'(scan_peak) * SCW'(WINDOW);
    assign score       = $signed(scan_prod) - SCW'($signed(scan_sum));
    assign scan_is_own = ({1'b0, 8'(r_scan_idx)} == {3'b000, i_active_channel});
    assign cost_full   = DW'(r_own) - DW'(r_best);

    // memory ports
    always_ff @(posedge i_clk) begin
        r_ring_rd <= ring_mem[ring_raddr];
        r_sum_rd  <= sum_mem[mem_addr];
        r_peak_rd <= peak_mem[mem_addr];
        if (i_cmd.clr_step) begin
            ring_mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit && do_avg) begin
            ring_mem[hold_ring_addr] <= r_sample;
        end
        if (i_cmd.commit && do_avg) begin
            sum_mem[hold_idx] <= new_sum;
        end
        if (i_cmd.commit && do_ana) begin
            peak_mem[hold_idx] <= new_peak;
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld   <= '0;
            r_peak_vld  <= '0;
            r_prev_mode <= RUN_STOP;
            r_mode      <= RUN_STOP;
            r_ring_pos  <= '0;
            r_clr_addr  <= '0;
            r_scan_cnt  <= '0;
            r_scan_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_prev_mode <= i_run_mode;
                r_clr_addr  <= '0;
                unique case (i_run_mode)
                    RUN_AVG:  r_mode <= RUN_AVG;
                    RUN_PEAK: r_mode <= RUN_PEAK;
                    default:  r_mode <= RUN_STOP;
                endcase
                if (o_stat.enter_avg) begin
                    r_sum_vld  <= '0;
                    r_ring_pos <= '0;
                end
                if (i_run_mode == RUN_PEAK && r_prev_mode != RUN_PEAK) begin
                    r_peak_vld <= '0;
                end
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + RAW'(1);
            end
            if (i_cmd.commit) begin
                if (do_avg) begin
                    r_sum_vld[hold_idx] <= 1'b1;
                end
                if (do_ana) begin
                    r_peak_vld[hold_idx] <= 1'b1;
                end
                if (r_mode == RUN_AVG && r_last) begin
                    r_ring_pos <= (r_ring_pos == PW'(WINDOW - 1)) ? '0 : r_ring_pos + PW'(1);
                end
                r_scan_cnt <= '0;
            end
            if (i_cmd.scan_step) begin
                r_scan_cnt <= r_scan_cnt + CHB'(1);
            end
            r_scan_v <= i_cmd.scan_step;
            // output register: drop on downstream take, set on load
            if (i_cmd.load_step || i_cmd.load_cost) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ch     <= i_channel;
            r_sample <= i_sample;
            r_last   <= i_record_end;
        end
        r_scan_idx <= r_scan_cnt;
        if (i_cmd.commit) begin
            r_best      <= '0;
            r_own       <= '0;
            r_step_sum  <= hold_in_range ? step_sum : '0;
            r_step_peak <= hold_in_range ? step_peak : '0;
        end else if (r_scan_v) begin
            if (scan_is_own) begin
                r_own <= score;
            end else if (score > r_best) begin
                r_best <= score;
            end
        end
        if (i_cmd.load_step) begin
            r_out_data <= {COST_W'(0), (hold_in_range ? step_peak : PEAK_W'(0)),
                           (hold_in_range ? step_sum : SUM_W'(0)), r_ch};
            r_out_user <= 1'b0;
        end else if (i_cmd.load_cost) begin
            r_out_data <= {COST_W'(cost_full), r_step_peak, r_step_sum, r_ch};
            r_out_user <= 1'b1;
        end
    end

    // status
    assign o_stat.enter_avg = (i_run_mode == RUN_AVG) && (r_prev_mode != RUN_AVG);
    assign o_stat.clr_last  = (r_clr_addr == RAW'(RD - 1));
    assign o_stat.cost_due  = (r_mode == RUN_PEAK) && r_last;
    assign o_stat.scan_last = (r_scan_cnt == CHB'(CHANNELS - 1));
    assign o_stat.out_free  = !r_out_valid || i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_user;

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_step || i_cmd.load_cost) |-> o_stat.out_free)
        else $error("output overwritten");

    // a cost is only produced for an analyse record end
    a_cost_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_cost |-> (r_mode == RUN_PEAK) && r_last)
        else $error("cost outside analyse record end");

    // ring position only moves at a take or a commit
    a_pos_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.commit) && !$past(i_cmd.take) |-> $stable(r_ring_pos))
        else $error("ring position moved unexpectedly");

endmodule

// ----- verif/tb_channel_window_average_peak_cost_core.sv -----
// ----------------------------------------------------------------------------
// tb_channel_window_average_peak_cost_core
// Self-checking bench for the window average and peak cost core: directed
// and random sample streams across mode changes, with a per-transaction model
// of the sums, peaks and record-end cost compared to every output transaction.
// ----------------------------------------------------------------------------
module tb_channel_window_average_peak_cost_core;
    import cwap_pkg::*;

    localparam int NCH   = 64;
    localparam int WIN   = 16;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [CH_W-1:0]   chan;
        logic [SUM_W-1:0]  wsum;
        logic [PEAK_W-1:0] pk;
        logic [COST_W-1:0] cst;
        logic              cvalid;
    } t_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // model state
    t_mode               mdl_mode;
    logic [CH_W-1:0]     mdl_active;
    t_mode               mdl_prev_mode;
    logic signed [15:0]  ring_mem [NCH*WIN];
    logic signed [31:0]  sum_mem [NCH];
    logic [16:0]         peak_mem [NCH];
    int                  ring_pos;

    t_result             expected_q[$];
    int                  fail_count;
    int                  cycle_count;
    bit                  idle_free;

    channel_window_average_peak_cost_core dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // predict the output of one sample and advance the model
    function automatic t_result predict_sample(logic [CH_W-1:0] ch, logic signed [15:0] s,
                                               logic last);
        t_result           r;
        logic signed [63:0] own;
        logic signed [63:0] best;
        logic signed [63:0] v;
        logic [16:0]       a;
        int                slot;
        t_mode             m;
        m = (mdl_mode == RUN_SPARE) ? RUN_STOP : mdl_mode;
        r = '0;
        if (m == RUN_AVG) begin
            if (mdl_prev_mode != RUN_AVG) begin
                foreach (ring_mem[i]) ring_mem[i] = '0;
                foreach (sum_mem[i]) sum_mem[i] = '0;
                ring_pos = 0;
            end
            slot = ch * WIN + ring_pos;
            sum_mem[ch] = sum_mem[ch] + s - ring_mem[slot];
            ring_mem[slot] = s;
            if (last) ring_pos = (ring_pos + 1) % WIN;
        end else if (m == RUN_PEAK) begin
            if (mdl_prev_mode != RUN_PEAK)
                foreach (peak_mem[i]) peak_mem[i] = '0;
            a = (s < 0) ? 17'(-32'(s)) : 17'(s);
            if (a > peak_mem[ch]) peak_mem[ch] = a;
            if (last) begin
                own = 0;
                best = 0;
                for (int c = 0; c < NCH; c++) begin
                    v = 64'(peak_mem[c]) * WIN - 64'(sum_mem[c]);
                    if (c == mdl_active) own = v;
                    else if (v > best) best = v;
                end
                r.cst = COST_W'(own - best);
                r.cvalid = 1'b1;
            end
        end
        mdl_prev_mode = mdl_mode;
        r.chan = ch;
        r.wsum = SUM_W'(sum_mem[ch]);
        r.pk = PEAK_W'(peak_mem[ch]);
        return r;
    endfunction

    function automatic bit idle_now();
        return !idle_free && ($urandom_range(99) < 16);
    endfunction

    // compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.chan   = m_axis_tdata[5:0];
            got.wsum   = m_axis_tdata[25:6];
            got.pk     = m_axis_tdata[41:26];
            got.cst    = m_axis_tdata[63:42];
            got.cvalid = m_axis_tuser;
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.chan !== want.chan) begin
                    $error("out_channel expected %0d got %0d", want.chan, got.chan);
                    fail_count++;
                end
                if (got.wsum !== want.wsum) begin
                    $error("window_sum expected %0h got %0h", want.wsum, got.wsum);
                    fail_count++;
                end
                if (got.pk !== want.pk) begin
                    $error("peak expected %0d got %0d", want.pk, got.pk);
                    fail_count++;
                end
                if (got.cst !== want.cst) begin
                    $error("cost expected %0h got %0h", want.cst, got.cst);
                    fail_count++;
                end
                if (got.cvalid !== want.cvalid) begin
                    $error("cost_valid expected %0b got %0b", want.cvalid, got.cvalid);
                    fail_count++;
                end
            end
        end
    end

    // randomly stall the result side
    always @(negedge i_clk) begin
        if (i_rst_n) m_axis_tready <= !idle_now();
    end

    // send one sample transaction and record its expectation; valid stays
    // up after the take until the next item or a drain replaces it
    task automatic send_sample(logic [CH_W-1:0] ch, logic [15:0] s, logic last);
        if (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while (idle_now()) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s, ch};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_sample(ch, s, last));
        @(negedge i_clk);
    endtask

    // drop valid, wait for all results, then for the longest scan to drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (NCH + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RUN_MODE) mdl_mode = t_mode'(value[1:0]);
        else mdl_active = value[5:0];
    endtask

    task automatic send_record(int len, bit wide);
        logic [15:0] s;
        for (int i = 0; i < len; i++) begin
            s = wide ? 16'($urandom) : 16'($urandom_range(0, 511) - 256);
            send_sample(6'($urandom_range(0, NCH - 1)), s, i == len - 1);
        end
    endtask

    // extremes of the fields in every mode, including the unused mode code
    task automatic test_directed();
        write_reg(ADDR_ACTIVE_CHANNEL, 0);
        send_sample(0, 16'h7fff, 1'b0);
        write_reg(ADDR_RUN_MODE, RUN_AVG);
        send_sample(0, 16'h7fff, 1'b0);
        send_sample(63, 16'h8000, 1'b1);
        send_sample(63, 16'hffff, 1'b1);
        send_sample(0, 16'h0001, 1'b1);
        write_reg(ADDR_RUN_MODE, RUN_PEAK);
        write_reg(ADDR_ACTIVE_CHANNEL, 63);
        send_sample(63, 16'h8000, 1'b0);
        send_sample(0, 16'h7fff, 1'b1);
        send_sample(42, 16'h5555, 1'b1);
        write_reg(ADDR_RUN_MODE, RUN_SPARE);
        send_sample(21, 16'haaaa, 1'b1);
        write_reg(ADDR_RUN_MODE, RUN_STOP);
        send_sample(63, 16'h0000, 1'b1);
        write_reg(ADDR_RUN_MODE, RUN_PEAK);
        send_sample(0, 16'h0000, 1'b1);
    endtask

    // random records over randomly chosen mode phases
    task automatic test_random_phases();
        int sent;
        sent = 0;
        while (sent < 1300) begin
            write_reg(ADDR_ACTIVE_CHANNEL, $urandom_range(0, 63));
            write_reg(ADDR_RUN_MODE, $urandom_range(0, 3));
            idle_free = ($urandom_range(9) == 0);
            for (int r = 0; r < 6; r++) begin
                int len;
                len = $urandom_range(1, 20);
                send_record(len, $urandom_range(3) == 0);
                sent += len;
            end
            idle_free = 1'b0;
        end
    endtask

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        idle_free     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mdl_mode      = RUN_STOP;
        mdl_prev_mode = RUN_STOP;
        mdl_active    = '0;
        ring_pos      = 0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        foreach (sum_mem[i]) sum_mem[i] = '0;
        foreach (peak_mem[i]) peak_mem[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_phases();
        drain();

        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
